@@ rtl/core/dics_pkg.sv @@
// ----------------------------------------------------------------------------
// dics_pkg
// Shared types and constants of the discrete inverse CDF sampler: operation
// codes, fixed-point widths and the controller state encoding.
// ----------------------------------------------------------------------------
package dics_pkg;

    localparam int FRAC_W = 16;
    localparam int TOT_W  = FRAC_W + 1;
    localparam int OP_W   = 2;

    localparam logic [TOT_W-1:0] ONE_FIXED = TOT_W'(1) << FRAC_W;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

endpackage

@@ rtl/core/dics_req_if.sv @@
// ----------------------------------------------------------------------------
// dics_req_if
// Request channel: operation code, probability mass and uniform fraction.
// ----------------------------------------------------------------------------
interface dics_req_if;

    logic                             valid;
    logic                             ready;
    logic [dics_pkg::OP_W-1:0]        operation;
    logic [dics_pkg::FRAC_W-1:0]      mass;
    logic [dics_pkg::FRAC_W-1:0]      uniform;

    modport source (
        output valid,
        input  ready,
        output operation,
        output mass,
        output uniform
    );

    modport sink (
        input  valid,
        output ready,
        input  operation,
        input  mass,
        input  uniform
    );

endinterface

@@ rtl/core/dics_rsp_if.sv @@
// ----------------------------------------------------------------------------
// dics_rsp_if
// Response channel: chosen outcome, flags and number of stored entries.
// ----------------------------------------------------------------------------
interface dics_rsp_if #(
    parameter int CNT_W = 7
);

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] outcome;
    logic             beyond_total;
    logic             table_full;
    logic [CNT_W-1:0] entry_count;

    modport source (
        output valid,
        input  ready,
        output outcome,
        output beyond_total,
        output table_full,
        output entry_count
    );

    modport sink (
        input  valid,
        output ready,
        input  outcome,
        input  beyond_total,
        input  table_full,
        input  entry_count
    );

endinterface

@@ rtl/core/discrete_inverse_cdf_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// discrete_inverse_cdf_sampler_unit
// Clear, append and sample requests: append stores the saturated running
// mass in the table, sample binary-searches the table for the outcome index.
// Clear, append, unused codes and empty-table samples go directly to the result state;
// a sample on a non-empty table runs a binary search with one table read per
// search step through the single read port.
// One request in flight; the next is taken once the result enters the output register.
// Reset clears the entry count, total and control; table contents stay undefined.
// ----------------------------------------------------------------------------
module discrete_inverse_cdf_sampler_unit #(
    parameter int MAX_OUTCOMES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    dics_req_if.sink      req,
    dics_rsp_if.source    rsp
);

    import dics_pkg::*;

    localparam int CNT_W = $clog2(MAX_OUTCOMES + 1);
    localparam int AW    = (MAX_OUTCOMES > 1) ? $clog2(MAX_OUTCOMES) : 1;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_OUTCOMES);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TOT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    mid_reg, mid_next;
    logic [FRAC_W-1:0]   u_reg, u_next;
    logic [CNT_W-1:0]    res_outcome_reg, res_outcome_next;
    logic                res_beyond_reg, res_beyond_next;
    logic                res_full_reg, res_full_next;

    logic                out_valid_reg;
    logic [CNT_W-1:0]    out_outcome_reg;
    logic                out_beyond_reg;
    logic                out_full_reg;
    logic [CNT_W-1:0]    out_count_reg;

    logic                accept;
    logic                load_out;
    logic [TOT_W:0]      sum;
    logic [TOT_W-1:0]    sat_total;
    logic [CNT_W-1:0]    half_count;
    logic                lt;
    logic [CNT_W-1:0]    lo_step;
    logic [CNT_W-1:0]    hi_step;
    logic [CNT_W-1:0]    mid_step;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [TOT_W-1:0]    rd_data;

    dics_cum_mem #(
        .DEPTH (MAX_OUTCOMES),
        .AW    (AW),
        .DW    (TOT_W)
    ) u_cum_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (sat_total),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign sum       = {1'b0, total_reg} + (TOT_W + 1)'(req.mass);
    assign sat_total = (sum > {1'b0, ONE_FIXED}) ? ONE_FIXED : sum[TOT_W-1:0];
    assign half_count = count_reg >> 1;

    assign lt       = rd_data < {1'b0, u_reg};
    assign lo_step  = lt ? (mid_reg + CNT_W'(1)) : lo_reg;
    assign hi_step  = lt ? hi_reg : mid_reg;
    assign mid_step = lo_step + ((hi_step - lo_step) >> 1);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        u_next           = u_reg;
        res_outcome_next = res_outcome_reg;
        res_beyond_next  = res_beyond_reg;
        res_full_next    = res_full_reg;
        wr_en            = 1'b0;
        wr_addr          = count_reg[AW-1:0];
        rd_en            = 1'b0;
        rd_addr          = mid_step[AW-1:0];
        load_out         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    u_next           = req.uniform;
                    res_outcome_next = '0;
                    res_beyond_next  = 1'b0;
                    res_full_next    = 1'b0;
                    state_next       = ST_RESULT;
                    unique case (req.operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg == MAX_CNT)
                            begin
                                res_full_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                total_next = sat_total;
                            end
                        end
                        OP_SAMPLE:
                        begin
                            res_beyond_next = {1'b0, req.uniform} > total_reg;
                            if (count_reg != '0)
                            begin
                                lo_next    = '0;
                                hi_next    = count_reg;
                                mid_next   = half_count;
                                rd_en      = 1'b1;
                                rd_addr    = half_count[AW-1:0];
                                state_next = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                lo_next = lo_step;
                hi_next = hi_step;
                if (lo_step < hi_step)
                begin
                    mid_next = mid_step;
                    rd_en    = 1'b1;
                end
                else
                begin
                    res_outcome_next = lo_step;
                    state_next       = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        mid_reg         <= mid_next;
        u_reg           <= u_next;
        res_outcome_reg <= res_outcome_next;
        res_beyond_reg  <= res_beyond_next;
        res_full_reg    <= res_full_next;
        if (load_out)
        begin
            out_outcome_reg <= res_outcome_reg;
            out_beyond_reg  <= res_beyond_reg;
            out_full_reg    <= res_full_reg;
            out_count_reg   <= count_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.outcome      = out_outcome_reg;
    assign rsp.beyond_total = out_beyond_reg;
    assign rsp.table_full   = out_full_reg;
    assign rsp.entry_count  = out_count_reg;

endmodule

@@ rtl/core/dics_cum_mem.sv @@
// ----------------------------------------------------------------------------
// dics_cum_mem
// Cumulative mass table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dics_cum_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 17
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ dv/discrete_inverse_cdf_sampler_unit_tb.sv @@
// ----------------------------------------------------------------------------
// discrete_inverse_cdf_sampler_unit_tb
// Drives clear, append, sample and unused requests into the sampler. Random
// idle cycles are inserted on both channels. Every response is checked
// field by field against a local model of the cumulative table. The stimulus
// covers an empty table, a saturated total, samples beyond the total, a full
// table, and random append runs each followed by a burst of samples.
// ----------------------------------------------------------------------------
module discrete_inverse_cdf_sampler_unit_tb;

    import dics_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int CNT_W        = 7;
    localparam int RANDOM_ITEMS = 700;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_IDLE     = 15;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] outcome;
        logic             beyond_total;
        logic             table_full;
        logic [CNT_W-1:0] entry_count;
    } draw_result_t;

    logic clk = 1'b0;
    logic rst_n;

    dics_req_if req ();
    dics_rsp_if #(.CNT_W(CNT_W)) rsp ();

    discrete_inverse_cdf_sampler_unit #(
        .MAX_OUTCOMES(TABLE_DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    logic [TOT_W-1:0] cdf_sums [TABLE_DEPTH];
    int unsigned      sum_count;
    logic [TOT_W-1:0] mass_total;

    draw_result_t pending_results [$];
    int unsigned  error_count;
    int unsigned  requests_sent;
    bit           sender_idles;
    bit           receiver_idles;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic draw_result_t predict_result(
        logic [OP_W-1:0]   op,
        logic [FRAC_W-1:0] mass,
        logic [FRAC_W-1:0] uni
    );
        draw_result_t r;
        logic [TOT_W:0] sum;
        r = '0;
        case (op)
            OP_CLEAR:
            begin
                sum_count  = 0;
                mass_total = '0;
            end
            OP_APPEND:
            begin
                if (sum_count >= TABLE_DEPTH)
                begin
                    r.table_full = 1'b1;
                end
                else
                begin
                    sum = {1'b0, mass_total} + (TOT_W + 1)'(mass);
                    mass_total = (sum > {1'b0, ONE_FIXED}) ? ONE_FIXED : sum[TOT_W-1:0];
                    cdf_sums[sum_count] = mass_total;
                    sum_count++;
                end
            end
            OP_SAMPLE:
            begin
                for (int i = 0; i < sum_count; i++)
                begin
                    if (cdf_sums[i] < {1'b0, uni})
                    begin
                        r.outcome = r.outcome + CNT_W'(1);
                    end
                end
                r.beyond_total = ({1'b0, uni} > mass_total);
            end
            default:
            begin
            end
        endcase
        r.entry_count = sum_count[CNT_W-1:0];
        return r;
    endfunction

    function automatic int unsigned idle_cycles(bit enabled);
        return enabled ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_request(
        logic [OP_W-1:0]   op,
        logic [FRAC_W-1:0] mass,
        logic [FRAC_W-1:0] uni
    );
        int unsigned gap;
        gap = idle_cycles(sender_idles);
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.mass      <= mass;
        req.uniform   <= uni;
        do @(posedge clk); while (!req.ready);
        pending_results.push_back(predict_result(op, mass, uni));
        if (op != OP_UNUSED)
        begin
            requests_sent++;
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        req.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // hold ready low for a drawn number of cycles, then high until a response passes
    initial
    begin
        int unsigned gap;
        rsp.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            gap = idle_cycles(receiver_idles);
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
        end
    end

    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("response with no request outstanding");
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.outcome !== want.outcome)
                begin
                    report_mismatch($sformatf("outcome got %0d want %0d",
                                              rsp.outcome, want.outcome));
                end
                if (rsp.beyond_total !== want.beyond_total)
                begin
                    report_mismatch($sformatf("beyond_total got %b want %b",
                                              rsp.beyond_total, want.beyond_total));
                end
                if (rsp.table_full !== want.table_full)
                begin
                    report_mismatch($sformatf("table_full got %b want %b",
                                              rsp.table_full, want.table_full));
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              rsp.entry_count, want.entry_count));
                end
            end
        end
    end

    function automatic logic [FRAC_W-1:0] pick_mass(int unsigned run_len);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return FRAC_W'($urandom);
            default: return FRAC_W'($urandom_range(0, (2 * 65536) / run_len));
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] pick_uniform();
        int probe;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3:
            begin
                if (sum_count == 0)
                begin
                    return FRAC_W'($urandom);
                end
                probe = int'(cdf_sums[$urandom_range(0, sum_count - 1)])
                        + $urandom_range(0, 2) - 1;
                if (probe < 0)
                begin
                    probe = 0;
                end
                if (probe > 65535)
                begin
                    probe = 65535;
                end
                return probe[FRAC_W-1:0];
            end
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    task automatic test_empty_table();
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_SAMPLE, '1, 16'h0000);
        send_request(OP_SAMPLE, '0, 16'h0001);
        send_request(OP_SAMPLE, '0, 16'hFFFF);
        send_request(OP_UNUSED, '1, '1);
        drain_results();
    endtask

    task automatic test_saturation();
        send_request(OP_APPEND, 16'h0000, '1);
        send_request(OP_APPEND, 16'h4000, '0);
        send_request(OP_APPEND, 16'hFFFF, '0);
        send_request(OP_APPEND, 16'h1234, '0);
        send_request(OP_SAMPLE, '0, 16'h0000);
        send_request(OP_SAMPLE, '0, 16'h4000);
        send_request(OP_SAMPLE, '0, 16'h4001);
        send_request(OP_SAMPLE, '0, 16'hFFFF);
        send_request(OP_UNUSED, '0, '0);
        drain_results();
    endtask

    task automatic test_beyond_total();
        send_request(OP_CLEAR, '1, '1);
        send_request(OP_APPEND, 16'h8000, '0);
        send_request(OP_SAMPLE, '0, 16'h7FFF);
        send_request(OP_SAMPLE, '0, 16'h8000);
        send_request(OP_SAMPLE, '0, 16'h8001);
        send_request(OP_SAMPLE, '0, 16'hFFFF);
        drain_results();
    endtask

    task automatic test_full_table();
        send_request(OP_CLEAR, '0, '0);
        repeat (TABLE_DEPTH)
        begin
            send_request(OP_APPEND, FRAC_W'($urandom_range(0, 1023)), '0);
        end
        send_request(OP_APPEND, 16'hFFFF, '0);
        send_request(OP_APPEND, 16'h0000, '0);
        send_request(OP_SAMPLE, '0, 16'h0000);
        send_request(OP_SAMPLE, '0, pick_uniform());
        send_request(OP_SAMPLE, '0, 16'hFFFF);
        send_request(OP_UNUSED, '0, '1);
        send_request(OP_CLEAR, '0, '0);
        drain_results();
    endtask

    task automatic test_random_sequences();
        int unsigned start;
        int unsigned run_len;
        int unsigned shape;
        start = requests_sent;
        while (requests_sent - start < RANDOM_ITEMS)
        begin
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
            begin
                send_request(OP_CLEAR, FRAC_W'($urandom), FRAC_W'($urandom));
            end
            shape = $urandom_range(0, 9);
            run_len = (shape < 7) ? $urandom_range(1, 12)
                    : (shape < 9) ? $urandom_range(13, 40)
                    : $urandom_range(55, 70);
            repeat (run_len)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_request(OP_UNUSED, FRAC_W'($urandom), FRAC_W'($urandom));
                end
                send_request(OP_APPEND, pick_mass(run_len), FRAC_W'($urandom));
            end
            repeat ($urandom_range(1, 12))
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_request(OP_W'($urandom_range(0, 3)), FRAC_W'($urandom),
                                 FRAC_W'($urandom));
                end
                send_request(OP_SAMPLE, FRAC_W'($urandom), pick_uniform());
            end
            if ($urandom_range(0, 9) == 0)
            begin
                drain_results();
            end
        end
        drain_results();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.operation  <= OP_CLEAR;
        req.mass       <= '0;
        req.uniform    <= '0;
        sum_count      = 0;
        mass_total     = '0;
        error_count    = 0;
        requests_sent  = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_saturation();
        test_beyond_total();
        test_full_table();
        test_random_sequences();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #(20 * 400000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
